>>> design/bmcd_pkg.sv
// ----------------------------------------------------------------------------
// bmcd_pkg: battery monitor CAN decoder shared definitions
// Message classes, result kinds, frame identifiers and the keepalive CRC table.
// ----------------------------------------------------------------------------
package bmcd_pkg;

   // Class of a queued word, decided by the front end
   typedef enum logic [2:0] {
      MSG_TICK        = 3'd0,
      MSG_BATT_STATUS = 3'd1,
      MSG_ISO_TEMP    = 3'd2,
      MSG_CHG_LIMIT   = 3'd3,
      MSG_POWER_LIMIT = 3'd4,
      MSG_SOC         = 3'd5,
      MSG_PACK_VOLT   = 3'd6,
      MSG_LINK_VOLT   = 3'd7
   } bmcd_msg_type;

   typedef struct packed {
      bmcd_msg_type msg;
      logic [63:0]  data;
   } bmcd_entry_type;

   typedef enum logic [1:0] {
      BACK_IDLE = 2'd0,
      BACK_PREP = 2'd1,
      BACK_EMIT = 2'd2
   } bmcd_back_state_type;

   // Received identifiers
   localparam logic [10:0] ID_BATT_STATUS = 11'h112;
   localparam logic [10:0] ID_ISO_TEMP    = 11'h1FA;
   localparam logic [10:0] ID_CHG_LIMIT   = 11'h2F5;
   localparam logic [10:0] ID_POWER_LIMIT = 11'h40D;
   localparam logic [10:0] ID_SOC         = 11'h432;
   localparam logic [10:0] ID_VOLT_RESP   = 11'h607;

   // Voltage response filter
   localparam logic [7:0]  RESP_SOURCE    = 8'hF1;
   localparam logic [7:0]  RESP_SERVICE   = 8'h62;
   localparam logic [15:0] DID_PACK_VOLT  = 16'hDDB4;
   localparam logic [15:0] DID_LINK_VOLT  = 16'hDD66;

   // Transmitted identifiers
   localparam logic [10:0] TX_ID_KEEPALIVE = 11'h12F;
   localparam logic [10:0] TX_ID_REQUEST   = 11'h6F1;

   // Result kinds
   localparam logic [3:0] KIND_KEEPALIVE = 4'd0;
   localparam logic [3:0] KIND_REQUEST   = 4'd1;
   localparam logic [3:0] KIND_UDC2      = 4'd2;
   localparam logic [3:0] KIND_UDCSW     = 4'd3;
   localparam logic [3:0] KIND_UDC       = 4'd4;
   localparam logic [3:0] KIND_SOC       = 4'd5;
   localparam logic [3:0] KIND_TMIN      = 4'd6;
   localparam logic [3:0] KIND_TMAX      = 4'd7;
   localparam logic [3:0] KIND_CHGLIM    = 4'd8;
   localparam logic [3:0] KIND_MAXIN     = 4'd9;
   localparam logic [3:0] KIND_MAXOUT    = 4'd10;
   localparam logic [3:0] KIND_ISO       = 4'd11;
   localparam logic [3:0] KIND_IDC       = 4'd12;
   localparam logic [3:0] KIND_POWER     = 4'd13;

   // Keepalive bytes 2..7 and the alive prefix of byte 1
   localparam logic [47:0] KEEPALIVE_TAIL = 48'h02_30_35_F1_1B_86;
   localparam logic [3:0]  ALIVE_PREFIX   = 4'h2;
   localparam logic [3:0]  ALIVE_LAST     = 4'd14;
   localparam logic [7:0]  CRC_INIT       = 8'h3F;
   localparam logic [7:0]  CRC_POLY       = 8'h1D;

   // Voltage request bytes 0..3 and the two identifier low bytes
   localparam logic [31:0] REQUEST_HEAD   = 32'hDD_22_03_07;
   localparam logic [7:0]  REQ_PACK_LO    = 8'hB4;
   localparam logic [7:0]  REQ_LINK_LO    = 8'h66;

   // Value thresholds in 0.1 V, offsets, constants
   localparam logic [15:0] PACK_VOLT_RESET = 16'd5000;
   localparam logic [15:0] UDC2_LIMIT      = 16'd4500;
   localparam logic [15:0] UDCSW_LIMIT     = 16'd2000;
   localparam logic [15:0] UDCSW_OFFSET    = 16'd200;
   localparam logic [32:0] UDCSW_TIMEOUT   = 33'd5000;
   localparam logic [32:0] ISO_OK_VALUE    = 33'd9999;
   localparam logic [16:0] CURRENT_OFFSET  = 17'd8192;
   localparam logic [7:0]  TEMP_OFFSET     = 8'd50;
   localparam logic [1:0]  ISO_FAULT_CODE  = 2'd2;
   localparam logic [7:0]  TIMEOUT_RESET   = 8'd10;
   // Reciprocals: x / 10 = (x * 104858) >> 20 for x < 2^18,
   // raw * 3 / 1000 = (raw * 805308) >> 28 for raw < 2^16
   localparam logic [16:0] RECIP_TEN       = 17'd104858;
   localparam logic [19:0] RECIP_KW        = 20'd805308;

   // Keepalive CRC for each alive count, 8 bits per entry, built at elaboration
   function automatic logic [127:0] build_crc_table();
      logic [127:0] tbl;
      logic [7:0]   crc;
      logic [7:0]   byte_val;
      logic [55:0]  bytes;
      int           a;
      int           i;
      int           k;
      tbl = '0;
      for (a = 0; a < 16; a++) begin
         bytes = {KEEPALIVE_TAIL, ALIVE_PREFIX, 4'(a)};
         crc   = CRC_INIT;
         for (i = 0; i < 7; i++) begin
            byte_val = bytes[i*8 +: 8];
            crc = crc ^ byte_val;
            for (k = 0; k < 8; k++) begin
               crc = crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY) : {crc[6:0], 1'b0};
            end
         end
         tbl[a*8 +: 8] = crc;
      end
      return tbl;
   endfunction

endpackage

>>> design/battery_monitor_can_decoder_unit.sv
// ----------------------------------------------------------------------------
// battery_monitor_can_decoder_unit: battery monitor CAN decoder
// Takes received CAN frames and 100 ms ticks; keeps battery values and emits
// keepalive, voltage request and parameter words on each tick.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one word per received frame (req_cmd low) or tick (req_cmd high).
//    Frames with identifiers of no interest are dropped by the classifier;
//    the rest pass through a short queue to the executor.
//  - csr_*: writes the link timeout in seconds; always ready. Write only
//    while the block is idle.
//  - rsp_*: result words through a single output register. A tick gives 13
//    or 14 words; rsp_last marks the final one.
// Timing:
//  - A frame at the queue head is taken and applied while the executor is idle.
//  - A tick passes the prepare state, which counts the timeout down and forms
//    the power product, then emits one word per cycle while the receiver is
//    ready, each word through the output register. It holds the executor
//    from the cycle that takes it from the queue until its last word loads.
//  - The input side keeps accepting while the queue has room, so frames
//    arriving during a tick's output are held, not refused.
// Reset: synchronous; clears the queue and the output valid flag, and puts the
// stored values to their defaults (pack voltage 500.0 V, timeout 10 s).
// A stalled receiver holds the output word and freezes the tick sequence.
// ----------------------------------------------------------------------------
module battery_monitor_can_decoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [10:0]        req_can_id,
   input  logic [63:0]        req_frame_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_wdata,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_out_kind,
   output logic [10:0]        rsp_tx_id,
   output logic [63:0]        rsp_tx_data,
   output logic signed [32:0] rsp_param_value,
   output logic               rsp_last
);

   logic                     push_valid;
   logic                     push_ready;
   bmcd_pkg::bmcd_entry_type push_entry;
   logic                     pop_valid;
   logic                     pop_ready;
   bmcd_pkg::bmcd_entry_type pop_entry;

   // configuration writes never stall
   assign csr_ready = 1'b1;

   // classify and drop frames of no interest
   bmcd_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_can_id     (req_can_id),
      .req_frame_data (req_frame_data),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_entry     (push_entry)
   );

   // hold words while the executor is busy emitting a tick
   bmcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // apply frames, sequence tick results
   bmcd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_wdata       (csr_wdata),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_entry       (pop_entry),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_tx_id       (rsp_tx_id),
      .rsp_tx_data     (rsp_tx_data),
      .rsp_param_value (rsp_param_value),
      .rsp_last        (rsp_last)
   );

endmodule

>>> design/bmcd_front.sv
// ----------------------------------------------------------------------------
// bmcd_front: request classifier
// Sorts each request word into a message class and drops frames that change
// nothing, so that only useful words enter the queue.
// ----------------------------------------------------------------------------
module bmcd_front (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_cmd,
   input  logic [10:0]              req_can_id,
   input  logic [63:0]              req_frame_data,
   output logic                     push_valid,
   input  logic                     push_ready,
   output bmcd_pkg::bmcd_entry_type push_entry
);

   logic                  keep;
   bmcd_pkg::bmcd_msg_type msg;
   logic [15:0]           did;

   assign did = {req_frame_data[31:24], req_frame_data[39:32]};

   always_comb begin
      keep = 1'b1;
      msg  = bmcd_pkg::MSG_TICK;
      if (!req_cmd) begin
         unique case (req_can_id)
            bmcd_pkg::ID_BATT_STATUS: msg = bmcd_pkg::MSG_BATT_STATUS;
            bmcd_pkg::ID_ISO_TEMP:    msg = bmcd_pkg::MSG_ISO_TEMP;
            bmcd_pkg::ID_CHG_LIMIT:   msg = bmcd_pkg::MSG_CHG_LIMIT;
            bmcd_pkg::ID_POWER_LIMIT: msg = bmcd_pkg::MSG_POWER_LIMIT;
            bmcd_pkg::ID_SOC:         msg = bmcd_pkg::MSG_SOC;
            bmcd_pkg::ID_VOLT_RESP: begin
               // drop responses from other sources, services or identifiers
               if (req_frame_data[7:0] == bmcd_pkg::RESP_SOURCE &&
                   req_frame_data[23:16] == bmcd_pkg::RESP_SERVICE &&
                   did == bmcd_pkg::DID_PACK_VOLT) begin
                  msg = bmcd_pkg::MSG_PACK_VOLT;
               end else if (req_frame_data[7:0] == bmcd_pkg::RESP_SOURCE &&
                            req_frame_data[23:16] == bmcd_pkg::RESP_SERVICE &&
                            did == bmcd_pkg::DID_LINK_VOLT) begin
                  msg = bmcd_pkg::MSG_LINK_VOLT;
               end else begin
                  keep = 1'b0;
               end
            end
            default: keep = 1'b0;
         endcase
      end
   end

   assign req_ready       = push_ready;
   assign push_valid      = req_valid && keep;
   assign push_entry.msg  = msg;
   assign push_entry.data = req_frame_data;

endmodule

>>> design/bmcd_queue.sv
// ----------------------------------------------------------------------------
// bmcd_queue: classified word queue
// Short first-in first-out buffer between the classifier and the executor.
// ----------------------------------------------------------------------------
module bmcd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  bmcd_pkg::bmcd_entry_type push_entry,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output bmcd_pkg::bmcd_entry_type pop_entry
);

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   bmcd_pkg::bmcd_entry_type entries_ff [DEPTH];
   logic [PtrWidth-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]    count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign push_ready = (count_ff != CountWidth'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> design/bmcd_back.sv
// ----------------------------------------------------------------------------
// bmcd_back: message executor
// Applies received frames to the stored battery values and, on a tick, walks
// the result sequence into the output register.
// ----------------------------------------------------------------------------
module bmcd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic [7:0]               csr_wdata,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  bmcd_pkg::bmcd_entry_type pop_entry,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [3:0]               rsp_out_kind,
   output logic [10:0]              rsp_tx_id,
   output logic [63:0]              rsp_tx_data,
   output logic signed [32:0]       rsp_param_value,
   output logic                     rsp_last
);

   localparam logic [127:0] CrcTable = bmcd_pkg::build_crc_table();

   bmcd_pkg::bmcd_back_state_type state_ff, state_in;
   logic [3:0]         step_ff, step_in, step_next;
   logic [3:0]         alive_ff, alive_in;
   logic               poll_ff, poll_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               load_out;

   logic [7:0]         timeout_sec_ff;
   logic [11:0]        link_timeout_ff;
   logic signed [16:0] pack_current_ff;
   logic signed [13:0] chg_limit_ff;
   logic [7:0]         temp_min_ff;
   logic [7:0]         temp_max_ff;
   logic [7:0]         soc_ff;
   logic [7:0]         chg_kw_ff;
   logic [7:0]         dis_kw_ff;
   logic [15:0]        pack_volt_ff;
   logic [15:0]        link_volt_ff;
   logic               iso_fault_ff;
   logic [3:0]         emerg_ff;
   logic signed [32:0] power_ff;

   logic [3:0]         rsp_kind_ff;
   logic [10:0]        rsp_id_ff;
   logic [63:0]        rsp_data_ff;
   logic signed [32:0] rsp_value_ff;
   logic               rsp_last_ff;

   logic [3:0]         out_kind;
   logic [10:0]        out_id;
   logic [63:0]        out_data;
   logic signed [32:0] out_value;
   logic               out_last;

   logic [63:0]        d;
   logic               take;
   logic signed [16:0] cur_new;
   logic signed [16:0] mc_new;
   logic [16:0]        mc_abs;
   logic [33:0]        mc_prod;
   logic [13:0]        mc_mag;
   logic [35:0]        chg_prod;
   logic [35:0]        dis_prod;
   logic signed [33:0] power_full;
   logic               link_alive;

   assign d    = pop_entry.data;
   assign take = pop_valid && pop_ready;

   // frame decoding
   assign cur_new  = $signed({d[15], d[15:0]}) - $signed(bmcd_pkg::CURRENT_OFFSET);
   assign mc_new   = $signed({d[31], d[31:16]}) - $signed(bmcd_pkg::CURRENT_OFFSET);
   assign mc_abs   = mc_new[16] ? (~mc_new + 17'd1) : mc_new;
   assign mc_prod  = mc_abs * bmcd_pkg::RECIP_TEN;
   assign mc_mag   = {1'b0, mc_prod[32:20]};
   assign chg_prod = d[15:0] * bmcd_pkg::RECIP_KW;
   assign dis_prod = d[31:16] * bmcd_pkg::RECIP_KW;

   assign power_full = $signed({1'b0, pack_volt_ff}) * pack_current_ff;
   assign link_alive = (link_timeout_ff != '0);

   // result fields for the current step
   always_comb begin
      out_kind  = step_ff;
      out_id    = '0;
      out_data  = '0;
      out_value = '0;
      out_last  = 1'b0;
      unique case (step_ff)
         bmcd_pkg::KIND_KEEPALIVE: begin
            out_id   = bmcd_pkg::TX_ID_KEEPALIVE;
            out_data = {bmcd_pkg::KEEPALIVE_TAIL, bmcd_pkg::ALIVE_PREFIX, alive_ff,
                        CrcTable[alive_ff*8 +: 8]};
         end
         bmcd_pkg::KIND_REQUEST: begin
            out_id   = bmcd_pkg::TX_ID_REQUEST;
            out_data = {24'd0, (poll_ff ? bmcd_pkg::REQ_LINK_LO : bmcd_pkg::REQ_PACK_LO),
                        bmcd_pkg::REQUEST_HEAD};
         end
         bmcd_pkg::KIND_UDC2:  out_value = {17'd0, pack_volt_ff};
         bmcd_pkg::KIND_UDCSW: out_value = {17'd0, pack_volt_ff - bmcd_pkg::UDCSW_OFFSET};
         bmcd_pkg::KIND_UDC:   out_value = {17'd0, link_volt_ff};
         bmcd_pkg::KIND_SOC:   out_value = {25'd0, soc_ff};
         bmcd_pkg::KIND_TMIN:  out_value = {{25{temp_min_ff[7]}}, temp_min_ff};
         bmcd_pkg::KIND_TMAX:  out_value = {{25{temp_max_ff[7]}}, temp_max_ff};
         bmcd_pkg::KIND_CHGLIM: begin
            if (link_alive && emerg_ff == '0) begin
               out_value = {{19{chg_limit_ff[13]}}, chg_limit_ff};
            end
         end
         bmcd_pkg::KIND_MAXIN:  out_value = {25'd0, chg_kw_ff};
         bmcd_pkg::KIND_MAXOUT: out_value = {25'd0, dis_kw_ff};
         bmcd_pkg::KIND_ISO: begin
            out_value = iso_fault_ff ? '0 : bmcd_pkg::ISO_OK_VALUE;
         end
         bmcd_pkg::KIND_IDC: begin
            if (link_alive) begin
               out_value = {{16{pack_current_ff[16]}}, pack_current_ff};
            end
         end
         bmcd_pkg::KIND_POWER: begin
            // closing word: power while the link lives, else a fixed udcsw
            out_last = 1'b1;
            if (link_alive) begin
               out_value = power_ff;
            end else begin
               out_kind  = bmcd_pkg::KIND_UDCSW;
               out_value = bmcd_pkg::UDCSW_TIMEOUT;
            end
         end
         default: out_kind = step_ff;
      endcase
   end

   // skip the voltage limit words that do not apply
   always_comb begin
      unique case (step_ff)
         bmcd_pkg::KIND_REQUEST: begin
            if (pack_volt_ff < bmcd_pkg::UDC2_LIMIT) begin
               step_next = bmcd_pkg::KIND_UDC2;
            end else if (pack_volt_ff > bmcd_pkg::UDCSW_LIMIT) begin
               step_next = bmcd_pkg::KIND_UDCSW;
            end else begin
               step_next = bmcd_pkg::KIND_UDC;
            end
         end
         bmcd_pkg::KIND_UDC2: begin
            step_next = (pack_volt_ff > bmcd_pkg::UDCSW_LIMIT) ?
                        bmcd_pkg::KIND_UDCSW : bmcd_pkg::KIND_UDC;
         end
         default: step_next = step_ff + 4'd1;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      alive_in     = alive_ff;
      poll_in      = poll_ff;
      rsp_valid_in = rsp_valid_ff;
      pop_ready    = 1'b0;
      load_out     = 1'b0;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         bmcd_pkg::BACK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid && pop_entry.msg == bmcd_pkg::MSG_TICK) begin
               state_in = bmcd_pkg::BACK_PREP;
            end
         end
         bmcd_pkg::BACK_PREP: begin
            step_in  = bmcd_pkg::KIND_KEEPALIVE;
            state_in = bmcd_pkg::BACK_EMIT;
         end
         bmcd_pkg::BACK_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               step_in      = step_next;
               if (step_ff == bmcd_pkg::KIND_KEEPALIVE) begin
                  alive_in = (alive_ff >= bmcd_pkg::ALIVE_LAST) ? '0 : alive_ff + 4'd1;
               end
               if (step_ff == bmcd_pkg::KIND_REQUEST) begin
                  poll_in = ~poll_ff;
               end
               if (step_ff == bmcd_pkg::KIND_POWER) begin
                  state_in = bmcd_pkg::BACK_IDLE;
               end
            end
         end
         default: state_in = bmcd_pkg::BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= bmcd_pkg::BACK_IDLE;
         step_ff         <= bmcd_pkg::KIND_KEEPALIVE;
         alive_ff        <= '0;
         poll_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         timeout_sec_ff  <= bmcd_pkg::TIMEOUT_RESET;
         link_timeout_ff <= '0;
         pack_current_ff <= '0;
         chg_limit_ff    <= '0;
         temp_min_ff     <= '0;
         temp_max_ff     <= '0;
         soc_ff          <= '0;
         chg_kw_ff       <= '0;
         dis_kw_ff       <= '0;
         pack_volt_ff    <= bmcd_pkg::PACK_VOLT_RESET;
         link_volt_ff    <= '0;
         iso_fault_ff    <= 1'b0;
         emerg_ff        <= '0;
         power_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         alive_ff     <= alive_in;
         poll_ff      <= poll_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            timeout_sec_ff <= csr_wdata;
         end
         if (state_ff == bmcd_pkg::BACK_PREP) begin
            // count the link timeout down and take the power product
            if (link_alive) begin
               link_timeout_ff <= link_timeout_ff - 12'd1;
            end
            power_ff <= power_full[32:0];
         end
         if (take) begin
            unique case (pop_entry.msg)
               bmcd_pkg::MSG_BATT_STATUS: begin
                  pack_current_ff <= cur_new;
                  emerg_ff        <= d[51:48];
                  link_timeout_ff <= {1'b0, timeout_sec_ff, 3'd0} +
                                     {3'd0, timeout_sec_ff, 1'b0};
               end
               bmcd_pkg::MSG_ISO_TEMP: begin
                  iso_fault_ff <= (d[1:0] == bmcd_pkg::ISO_FAULT_CODE) ||
                                  (d[3:2] == bmcd_pkg::ISO_FAULT_CODE) ||
                                  (d[23:22] == bmcd_pkg::ISO_FAULT_CODE);
                  temp_min_ff  <= d[55:48] - bmcd_pkg::TEMP_OFFSET;
                  temp_max_ff  <= d[63:56] - bmcd_pkg::TEMP_OFFSET;
               end
               bmcd_pkg::MSG_CHG_LIMIT: begin
                  chg_limit_ff <= mc_new[16] ? (~mc_mag + 14'd1) : mc_mag;
               end
               bmcd_pkg::MSG_POWER_LIMIT: begin
                  chg_kw_ff <= chg_prod[35:28];
                  dis_kw_ff <= dis_prod[35:28];
               end
               bmcd_pkg::MSG_SOC:       soc_ff       <= d[39:32];
               bmcd_pkg::MSG_PACK_VOLT: pack_volt_ff <= {d[47:40], d[55:48]};
               bmcd_pkg::MSG_LINK_VOLT: link_volt_ff <= {d[47:40], d[55:48]};
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_kind_ff  <= out_kind;
         rsp_id_ff    <= out_id;
         rsp_data_ff  <= out_data;
         rsp_value_ff <= out_value;
         rsp_last_ff  <= out_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_kind    = rsp_kind_ff;
   assign rsp_tx_id       = rsp_id_ff;
   assign rsp_tx_data     = rsp_data_ff;
   assign rsp_param_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
